// ===== rtl/core/ipv4_tcp_checksum_rewrite_top_macros.svh =====
// assertion macros for the ipv4 checksum rewrite block
// used by the checker module; relies on clk and rst_n in the using scope
`ifndef IPV4_TCP_CHECKSUM_REWRITE_TOP_MACROS_SVH
`define IPV4_TCP_CHECKSUM_REWRITE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define IPCSR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPCSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ipcsr_pkg.sv =====
// shared types, constants and helper functions for the ipv4 checksum rewrite block
// no dependencies
package ipcsr_pkg;

    localparam logic [16:0] MAX_PACKET_BYTES = 17'd65535;

    localparam logic [3:0]  MIN_IHL          = 4'd5;
    localparam logic [15:0] IP_CSUM_WORD     = 16'd5;
    localparam logic [15:0] TCP_CSUM_OFFSET  = 16'd8;
    localparam logic [16:0] IP_MIN_BYTES     = 17'd20;
    localparam logic [16:0] TCP_MIN_BYTES    = 17'd40;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;

    // configuration register indexes
    localparam logic REG_REWRITE_MODE = 1'b0;
    localparam logic REG_NEW_ADDRESS  = 1'b1;

    // rewrite modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SRC  = 2'd1;
    localparam logic [1:0] MODE_DST  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HDR_SHORT = 3'd1;
    localparam logic [2:0] ST_NOT_TCP   = 3'd2;
    localparam logic [2:0] ST_TCP_SHORT = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    typedef struct packed {
        logic [1:0]  rewrite_mode;
        logic [31:0] new_address;
    } cfg_t;

    // per-packet accumulation state, also the word handed to the finish stage
    typedef struct packed {
        logic [15:0] header_sum;
        logic [15:0] segment_sum;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [16:0] byte_total;
    } snap_t;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== rtl/core/ipcsr_acc.sv =====
// per-word accumulation: field capture, address rewrite, header and segment sums
// depends on ipcsr_pkg
module ipcsr_acc
    import ipcsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [15:0] word_in,
    input  logic        both_in,
    input  logic        last_in,
    input  cfg_t        cfg,
    output snap_t       snap
);

    snap_t       state_reg, state_next;
    logic [15:0] wp_reg, wp_next;

    logic [15:0] w_in, w_sat, w_rw, seg_val, wp_upd;
    logic [16:0] bt_sum, off1, tl_ext;
    logic [4:0]  hdr_limit;
    logic [15:0] hdr_limit_ext;
    logic        active, over, hdr_hit, pseudo, body, full, half, seg_hit;
    snap_t       upd;

    always_comb
    begin
        w_in   = both_in ? word_in : {word_in[15:8], 8'h00};
        active = (state_reg.byte_total < MAX_PACKET_BYTES);
        bt_sum = state_reg.byte_total + (both_in ? 17'd2 : 17'd1);
        over   = (bt_sum > MAX_PACKET_BYTES);
        w_sat  = over ? {w_in[15:8], 8'h00} : w_in;

        upd            = state_reg;
        upd.byte_total = over ? MAX_PACKET_BYTES : bt_sum;
        if (wp_reg == 16'd0)
        begin
            upd.header_words = w_sat[11:8];
        end
        if (wp_reg == 16'd1)
        begin
            upd.total_length = w_sat;
        end
        if (wp_reg == 16'd4)
        begin
            upd.protocol = w_sat[7:0];
        end

        // address substitution, after field capture
        w_rw = w_sat;
        case (cfg.rewrite_mode)
            MODE_SRC:
            begin
                if (wp_reg == 16'd6)
                begin
                    w_rw = cfg.new_address[31:16];
                end
                else if (wp_reg == 16'd7)
                begin
                    w_rw = cfg.new_address[15:0];
                end
            end
            MODE_DST:
            begin
                if (wp_reg == 16'd8)
                begin
                    w_rw = cfg.new_address[31:16];
                end
                else if (wp_reg == 16'd9)
                begin
                    w_rw = cfg.new_address[15:0];
                end
            end
            default:
            begin
                w_rw = w_sat;
            end
        endcase

        hdr_limit     = {upd.header_words, 1'b0};
        hdr_limit_ext = {11'd0, hdr_limit};
        hdr_hit       = (wp_reg < hdr_limit_ext) && (wp_reg != IP_CSUM_WORD);

        // pseudo-header addresses
        pseudo = (wp_reg >= 16'd6) && (wp_reg <= 16'd9);

        // segment words up to total length, skipping the tcp checksum
        body   = (upd.header_words >= MIN_IHL) && (wp_reg >= hdr_limit_ext)
                 && (wp_reg != (hdr_limit_ext + TCP_CSUM_OFFSET));
        off1   = {wp_reg, 1'b1};
        tl_ext = {1'b0, upd.total_length};
        full   = (off1 < tl_ext);
        half   = (off1 == tl_ext);
        seg_hit = pseudo || (body && (full || half));
        seg_val = (!pseudo && half) ? {w_rw[15:8], 8'h00} : w_rw;

        if (hdr_hit)
        begin
            upd.header_sum = oc_add(state_reg.header_sum, w_rw);
        end
        if (seg_hit)
        begin
            upd.segment_sum = oc_add(state_reg.segment_sum, seg_val);
        end

        wp_upd = (wp_reg == 16'hffff) ? wp_reg : wp_reg + 16'd1;

        // oversize packets stop counting once the byte limit is hit
        snap = active ? upd : state_reg;

        state_next = state_reg;
        wp_next    = wp_reg;
        if (adv)
        begin
            if (last_in)
            begin
                state_next = '0;
                wp_next    = 16'd0;
            end
            else
            begin
                state_next = snap;
                wp_next    = active ? wp_upd : wp_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            wp_reg    <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
        end
    end

endmodule

// ===== rtl/core/ipcsr_fin.sv =====
// end-of-packet stage: status decision, pseudo-header finish, result register
// depends on ipcsr_pkg
module ipcsr_fin
    import ipcsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        snap_load,
    input  snap_t       snap_in,
    output logic        free,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] ip_checksum,
    output logic [15:0] tcp_checksum,
    output logic [2:0]  status
);

    logic        b_vld_reg, b_vld_next;
    snap_t       snap_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] ipc_reg, tcpc_reg;
    logic [2:0]  status_reg;

    logic        b_adv;
    logic [16:0] hb;
    logic [15:0] diff, s1, s2, ipc, tcpc;
    logic [2:0]  st;

    always_comb
    begin
        b_adv = b_vld_reg && (!out_valid_reg || !out_stall);
        free  = !b_vld_reg || b_adv;

        hb = {11'd0, snap_reg.header_words, 2'b00};

        if ((snap_reg.header_words < MIN_IHL) || (snap_reg.byte_total < IP_MIN_BYTES)
            || (snap_reg.byte_total < hb))
        begin
            st = ST_HDR_SHORT;
        end
        else if (snap_reg.protocol != PROTO_TCP)
        begin
            st = ST_NOT_TCP;
        end
        else if (snap_reg.byte_total < TCP_MIN_BYTES)
        begin
            st = ST_TCP_SHORT;
        end
        else if (({1'b0, snap_reg.total_length} < hb)
                 || (snap_reg.byte_total < {1'b0, snap_reg.total_length}))
        begin
            st = ST_TRUNC;
        end
        else
        begin
            st = ST_OK;
        end

        diff = snap_reg.total_length - hb[15:0];
        s1   = oc_add(snap_reg.segment_sum, {8'd0, snap_reg.protocol});
        s2   = oc_add(s1, diff);

        case (st) inside
            ST_OK, ST_NOT_TCP, ST_TCP_SHORT: ipc = ~snap_reg.header_sum;
            default:                         ipc = 16'd0;
        endcase
        tcpc = (st == ST_OK) ? ~s2 : 16'd0;

        b_vld_next     = snap_load || (b_vld_reg && !b_adv);
        out_valid_next = b_adv || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg     <= b_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_reg <= snap_in;
        end
        if (b_adv)
        begin
            ipc_reg    <= ipc;
            tcpc_reg   <= tcpc;
            status_reg <= st;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ip_checksum  = ipc_reg;
    assign tcp_checksum = tcpc_reg;
    assign status       = status_reg;

endmodule

// ===== rtl/core/ipv4_tcp_checksum_rewrite_top.sv =====
// ipv4 header and tcp checksum with address rewrite: one 16-bit word per cycle
// a last word waits for finish room, then moves to snapshot and result registers
// throughput: one word per cycle; set by the single accumulate stage's sum loop
// reset (rst_n, async low) clears config to no substitution and all packet state
// depends on ipcsr_pkg, ipcsr_acc, ipcsr_fin
module ipv4_tcp_checksum_rewrite_top
    import ipcsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input word channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] word,
    input  logic        both_bytes,
    input  logic        last,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] ip_checksum,
    output logic [15:0] tcp_checksum,
    output logic [2:0]  status
);

    // configuration registers
    cfg_t        cfg_reg, cfg_next;

    // input register: holds one word ahead of the accumulator
    logic        a_vld_reg, a_vld_next;
    logic [15:0] a_word_reg;
    logic        a_both_reg;
    logic        a_last_reg;

    logic        in_take;
    logic        a_adv;
    logic        fin_free;
    snap_t       snap;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REWRITE_MODE: cfg_next.rewrite_mode = cfg_data[1:0];
                REG_NEW_ADDRESS:  cfg_next.new_address  = cfg_data;
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    // handshake glue: a non-last word always moves on; a last word needs the
    // finish stage to have room, which is the only way back-pressure reaches
    // the input side
    always_comb
    begin
        a_adv      = a_vld_reg && (!a_last_reg || fin_free);
        in_stall   = a_vld_reg && !a_adv;
        in_take    = in_valid && !in_stall;
        a_vld_next = in_take || (a_vld_reg && !a_adv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            a_vld_reg <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            a_vld_reg <= a_vld_next;
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_word_reg <= word;
            a_both_reg <= both_bytes;
            a_last_reg <= last;
        end
    end

    // running sums and captured header fields, cleared after each last word
    ipcsr_acc u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (a_adv),
        .word_in (a_word_reg),
        .both_in (a_both_reg),
        .last_in (a_last_reg),
        .cfg     (cfg_reg),
        .snap    (snap)
    );

    // status and final checksums for a completed packet
    ipcsr_fin u_fin (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_load    (a_adv && a_last_reg),
        .snap_in      (snap),
        .free         (fin_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ip_checksum  (ip_checksum),
        .tcp_checksum (tcp_checksum),
        .status       (status)
    );

endmodule

// ===== rtl/core/ipcsr_checker.sv =====
// port-level checks on the result channel of the checksum rewrite block
// depends on ipcsr_pkg and ipv4_tcp_checksum_rewrite_top_macros.svh
`include "ipv4_tcp_checksum_rewrite_top_macros.svh"

module ipcsr_checker
    import ipcsr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] ip_checksum,
    input logic [15:0] tcp_checksum,
    input logic [2:0]  status
);

    `IPCSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(ip_checksum) && $stable(tcp_checksum), "stalled result word changed")

    `IPCSR_ASSERT_IMPLY(a_status_range, out_valid, status <= ST_TRUNC, "status code out of range")

    `IPCSR_ASSERT_IMPLY(a_tcp_zero, out_valid && (status != ST_OK), tcp_checksum == 16'd0, "tcp checksum not zero on failed status")

    `IPCSR_ASSERT_IMPLY(a_ip_zero, out_valid && ((status == ST_HDR_SHORT) || (status == ST_TRUNC)), ip_checksum == 16'd0, "ip checksum not zero on short or truncated packet")

endmodule

bind ipv4_tcp_checksum_rewrite_top ipcsr_checker u_checker (.*);
